// ===== rtl/efmp_pkg.sv =====
// shared types and constants for the extension field multiply / power block
// no dependencies
package efmp_pkg;
    localparam int LANE_W = 8;
    localparam int LANES_MAX = 12;
    localparam int RES_W = 64 + 32;
    localparam logic [1:0] CMD_NONE = 2'd0;
    localparam logic [1:0] CMD_MUL = 2'd1;
    localparam logic [1:0] CMD_SQR = 2'd2;

    typedef struct packed {
        logic       load;
        logic       start;
        logic [1:0] op;
        logic       commit;
    } efmp_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } efmp_sts_t;
endpackage

// ===== rtl/efmp_ctrl.sv =====
// sequencer for multiply and power: walks exponent bits for power and issues field multiplies
// depends on efmp_pkg
module efmp_ctrl #(
    parameter int EXP_BITS = 89
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  go,
    input  logic                  is_pow,
    input  logic [127:0]          exp_in,
    input  efmp_pkg::efmp_sts_t   sts,
    output efmp_pkg::efmp_cmd_t   cmd,
    output logic                  finish
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_MWT  = 3'd2;
    localparam logic [2:0] ST_SQ   = 3'd3;
    localparam logic [2:0] ST_SWT  = 3'd4;
    localparam logic [2:0] ST_ONE  = 3'd5;
    localparam logic [2:0] ST_OWT  = 3'd6;
    localparam int CW = $clog2(EXP_BITS + 1);

    logic [2:0]          state_reg, state_next;
    logic [EXP_BITS-1:0] exp_reg, exp_next;
    logic [CW-1:0]       cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        exp_reg <= exp_next;
        cnt_reg <= cnt_next;
    end

    always_comb begin
        state_next = state_reg;
        exp_next = exp_reg;
        cnt_next = cnt_reg;
        cmd = '0;
        finish = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (go) begin
                    cmd.load = 1'b1;
                    exp_next = exp_in[EXP_BITS-1:0];
                    cnt_next = '0;
                    state_next = is_pow ? ST_MUL : ST_ONE;
                end
            end
            ST_ONE: begin
                cmd.start = 1'b1;
                cmd.op = efmp_pkg::CMD_MUL;
                state_next = ST_OWT;
            end
            ST_OWT: begin
                if (sts.done) begin
                    cmd.commit = 1'b1;
                    finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_MUL: begin
                if (exp_reg[0]) begin
                    cmd.start = 1'b1;
                    cmd.op = efmp_pkg::CMD_MUL;
                    state_next = ST_MWT;
                end else begin
                    state_next = ST_SQ;
                end
            end
            ST_MWT: begin
                if (sts.done) begin
                    cmd.commit = 1'b1;
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                cmd.start = 1'b1;
                cmd.op = efmp_pkg::CMD_SQR;
                state_next = ST_SWT;
            end
            ST_SWT: begin
                if (sts.done) begin
                    cmd.commit = 1'b1;
                    exp_next = exp_reg >> 1;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == CW'(EXP_BITS - 1)) begin
                        finish = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_MUL;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

// ===== rtl/efmp_datapath.sv =====
// field multiplier on a row of DEGREE mod-p multiply-accumulates, plus operand registers
// depends on efmp_pkg
module efmp_datapath #(
    parameter int PRIME  = 167,
    parameter int DEGREE = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  efmp_pkg::efmp_cmd_t   cmd,
    input  logic [95:0]           a_in,
    input  logic [95:0]           b_in,
    input  logic [95:0]           rel_in,
    input  logic                  mul_mode,
    output efmp_pkg::efmp_sts_t   sts,
    output logic [95:0]           result
);
    localparam int W = 2 * DEGREE - 1;
    localparam int IW = $clog2(DEGREE);
    localparam int DW = $clog2(W);
    localparam int PW = $clog2(PRIME);
    // reduction by reciprocal multiply: estimate is at most one short
    localparam int TW = (2 * PW + 1 > 9) ? 2 * PW + 1 : 9;
    localparam int RS = TW + 1;
    localparam int RM = (1 << RS) / PRIME;
    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_PROD = 2'd1;
    localparam logic [1:0] P_FOLD = 2'd2;

    logic [PW-1:0] res_reg [DEGREE];
    logic [PW-1:0] base_reg [DEGREE];
    logic [PW-1:0] rel_reg [DEGREE];
    logic [PW-1:0] x_reg [DEGREE];
    logic [PW-1:0] y_reg [DEGREE];
    logic [PW-1:0] work_reg [W];
    logic [1:0]    ph_reg;
    logic [IW-1:0] i_reg;
    logic [DW-1:0] d_reg;
    logic          sq_reg;
    logic          done_reg;

    function automatic logic [PW-1:0] redp(input logic [TW-1:0] t);
        logic [TW+RS-1:0] qe;
        logic [TW-1:0]    q;
        logic [TW-1:0]    r;
        qe = (TW+RS)'(t) * (TW+RS)'(RM);
        q = qe[TW+RS-1:RS];
        r = t - q * TW'(PRIME);
        return (r >= TW'(PRIME)) ? PW'(r - TW'(PRIME)) : PW'(r);
    endfunction

    function automatic logic [PW-1:0] modp(input logic [7:0] v);
        return redp(TW'(v));
    endfunction

    function automatic logic [PW-1:0] mulmod(input logic [PW-1:0] p, input logic [PW-1:0] q,
                                             input logic [PW-1:0] acc);
        logic [TW-1:0] t;
        t = TW'(p) * TW'(q) + TW'(acc);
        return redp(t);
    endfunction

    // one row of partial products or one fold step a cycle
    logic [PW-1:0] row_k;
    always_comb begin
        row_k = (ph_reg == P_PROD) ? x_reg[i_reg] : work_reg[d_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg <= P_IDLE;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (ph_reg)
                P_IDLE: if (cmd.start) ph_reg <= P_PROD;
                P_PROD: if (i_reg == IW'(DEGREE - 1)) ph_reg <= P_FOLD;
                P_FOLD: if (d_reg == DW'(DEGREE)) begin
                    ph_reg <= P_IDLE;
                    done_reg <= 1'b1;
                end
                default: ph_reg <= P_IDLE;
            endcase
        end
        if (cmd.load) begin
            for (int k = 0; k < DEGREE; k++) begin
                base_reg[k] <= modp(a_in[8*k +: 8]);
                rel_reg[k] <= modp(rel_in[8*k +: 8]);
                res_reg[k] <= mul_mode ? modp(b_in[8*k +: 8]) : ((k == 0) ? PW'(1) : '0);
            end
        end
        if (cmd.start) begin
            sq_reg <= (cmd.op == efmp_pkg::CMD_SQR);
            for (int k = 0; k < DEGREE; k++) begin
                x_reg[k] <= (cmd.op == efmp_pkg::CMD_SQR) ? base_reg[k] : res_reg[k];
                y_reg[k] <= base_reg[k];
            end
            for (int k = 0; k < W; k++) work_reg[k] <= '0;
            i_reg <= '0;
            d_reg <= DW'(W - 1);
        end else if (ph_reg == P_PROD) begin
            for (int j = 0; j < DEGREE; j++)
                work_reg[int'(i_reg) + j] <= mulmod(row_k, y_reg[j],
                                                   work_reg[int'(i_reg) + j]);
            i_reg <= i_reg + 1'b1;
        end else if (ph_reg == P_FOLD) begin
            for (int j = 0; j < DEGREE; j++)
                work_reg[int'(d_reg) - DEGREE + j] <= mulmod(row_k, rel_reg[j],
                                                    work_reg[int'(d_reg) - DEGREE + j]);
            d_reg <= d_reg - 1'b1;
        end
        if (cmd.commit) begin
            for (int k = 0; k < DEGREE; k++) begin
                if (sq_reg) base_reg[k] <= work_reg[k];
                else res_reg[k] <= work_reg[k];
            end
        end
    end

    assign sts.busy = (ph_reg != P_IDLE);
    assign sts.done = done_reg;

    always_comb begin
        result = '0;
        for (int k = 0; k < DEGREE; k++) result[8*k +: 8] = 8'(res_reg[k]);
    end
endmodule

// ===== rtl/extension_field_mul_pow.sv =====
// extension field multiply / power over GF(PRIME^DEGREE), top level
// power squares once per exponent bit and multiplies once per set bit on the row-at-a-time array
// one item in the datapath, one in the output register; next accept in the cycle after handover
// reset: synchronous active-low aresetn clears control and both relation registers
// depends on efmp_pkg, efmp_ctrl, efmp_datapath
module extension_field_mul_pow #(
    parameter int PRIME    = 167,
    parameter int DEGREE   = 12,
    parameter int EXP_BITS = 89
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [63:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [287:0] s_tdata,  // a_low, a_high, b_low, b_high, exp_low, exp_high, zero fill
    input  logic         s_tuser,  // req_type
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,  // result_low, result_high
    output logic         m_tuser   // result_is_zero
);
    logic [63:0] rel_low_reg;
    logic [31:0] rel_high_reg;
    logic        busy_reg;
    logic        mv_reg;
    logic        hold_reg;
    logic        move;
    logic [95:0] out_reg;
    logic        zero_reg;
    logic        go;
    logic        finish;
    logic [95:0] dp_res;
    logic [127:0] exp_in;
    efmp_pkg::efmp_cmd_t cmd;
    efmp_pkg::efmp_sts_t sts;

    // config registers, index 0 low word, index 1 high word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rel_low_reg <= '0;
            rel_high_reg <= '0;
        end else if (cfg_we) begin
            if (cfg_index == 1'b0) rel_low_reg <= cfg_wdata;
            else rel_high_reg <= cfg_wdata[31:0];
        end
    end

    // accept when the datapath holds nothing; the output register decouples the sink
    assign s_tready = !busy_reg;
    assign go = s_tvalid && s_tready;
    assign exp_in = {39'd0, s_tdata[280:192]};

    efmp_ctrl #(.EXP_BITS(EXP_BITS)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .go(go), .is_pow(s_tuser),
        .exp_in(exp_in), .sts(sts), .cmd(cmd), .finish(finish)
    );

    efmp_datapath #(.PRIME(PRIME), .DEGREE(DEGREE)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd),
        .a_in(s_tdata[95:0]), .b_in(s_tdata[191:96]),
        .rel_in({rel_high_reg, rel_low_reg}), .mul_mode(!s_tuser),
        .sts(sts), .result(dp_res)
    );

    // result is visible in the cycle after the final commit; it waits in the datapath
    // while the output register still holds an untaken transfer
    logic fin_d_reg;
    assign move = (fin_d_reg || hold_reg) && (!mv_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            mv_reg <= 1'b0;
            hold_reg <= 1'b0;
            fin_d_reg <= 1'b0;
        end else begin
            fin_d_reg <= finish;
            if (go) busy_reg <= 1'b1;
            else if (move) busy_reg <= 1'b0;
            if (move) hold_reg <= 1'b0;
            else if (fin_d_reg) hold_reg <= 1'b1;
            if (move) mv_reg <= 1'b1;
            else if (m_tready) mv_reg <= 1'b0;
        end
        if (move) begin
            out_reg <= dp_res;
            zero_reg <= (dp_res == '0);
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata = out_reg;
    assign m_tuser = zero_reg;

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !s_tready) else $error("accept while busy");
    a_fin_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        finish |-> busy_reg) else $error("finish without item");
    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid) else $error("result dropped");
`endif
endmodule

// ===== dv/efmp_checker.sv =====
// checker for extension_field_mul_pow: follows both streams and the register port,
// predicts each result over GF(167^12) and compares it field by field
// needs only the port list of the block
`timescale 1ns / 100ps

module efmp_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [63:0]  cfg_wdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [287:0] s_tdata,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [95:0]  m_tdata,
    input  logic         m_tuser,
    output int           mismatches,
    output int           awaiting
);
    localparam int FIELD_P = 167;
    localparam int FIELD_N = 12;
    localparam int POW_BITS = 89;
    localparam logic REQ_MUL = 1'b0;

    typedef int coeffs_t [FIELD_N];

    typedef struct {
        logic [63:0] res_low;
        logic [31:0] res_high;
        logic        res_zero;
    } field_result_t;

    logic [63:0] rel_low_q;
    logic [31:0] rel_high_q;
    field_result_t expected_results[$];

    function automatic coeffs_t to_coeffs(input logic [95:0] packed_v);
        coeffs_t c;
        for (int i = 0; i < FIELD_N; i++) c[i] = int'(packed_v[8*i +: 8]) % FIELD_P;
        return c;
    endfunction

    // schoolbook product, then fold degrees 22..12 through the relation
    function automatic coeffs_t gf_mul(input coeffs_t x, input coeffs_t y,
                                       input coeffs_t rel);
        int work[2*FIELD_N-1];
        coeffs_t r;
        for (int i = 0; i < 2*FIELD_N-1; i++) work[i] = 0;
        for (int i = 0; i < FIELD_N; i++)
            for (int j = 0; j < FIELD_N; j++)
                work[i+j] = (work[i+j] + x[i] * y[j]) % FIELD_P;
        for (int d = 2*FIELD_N-2; d >= FIELD_N; d--)
            for (int i = 0; i < FIELD_N; i++)
                work[d-FIELD_N+i] = (work[d-FIELD_N+i] + work[d] * rel[i]) % FIELD_P;
        for (int i = 0; i < FIELD_N; i++) r[i] = work[i];
        return r;
    endfunction

    function automatic field_result_t field_op(input logic req, input logic [287:0] d);
        coeffs_t rel, base, acc;
        logic [88:0] ex;
        field_result_t fr;
        rel  = to_coeffs({rel_high_q, rel_low_q});
        base = to_coeffs(d[95:0]);
        ex   = d[280:192];
        if (req == REQ_MUL) begin
            acc = gf_mul(base, to_coeffs(d[191:96]), rel);
        end else begin
            foreach (acc[i]) acc[i] = 0;
            acc[0] = 1;
            for (int i = 0; i < POW_BITS; i++) begin
                if (ex[i]) acc = gf_mul(acc, base, rel);
                base = gf_mul(base, base, rel);
            end
        end
        fr.res_zero = 1'b1;
        fr.res_low = '0;
        fr.res_high = '0;
        for (int i = 0; i < FIELD_N; i++) begin
            if (acc[i] != 0) fr.res_zero = 1'b0;
            if (i < 8) fr.res_low[8*i +: 8] = acc[i][7:0];
            else       fr.res_high[8*(i-8) +: 8] = acc[i][7:0];
        end
        return fr;
    endfunction

    assign awaiting = expected_results.size();

    always @(posedge aclk) begin
        field_result_t exp_r;
        int errs;
        errs = 0;
        if (!aresetn) begin
            rel_low_q  <= '0;
            rel_high_q <= '0;
            mismatches <= 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index) rel_high_q <= cfg_wdata[31:0];
                else           rel_low_q  <= cfg_wdata;
            end
            if (s_tvalid && s_tready)
                expected_results = {expected_results, field_op(s_tuser, s_tdata)};
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with nothing expected: %h", m_tdata);
                    errs++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (m_tdata[63:0] !== exp_r.res_low) begin
                        $error("result_low expected %h actual %h", exp_r.res_low,
                               m_tdata[63:0]);
                        errs++;
                    end
                    if (m_tdata[95:64] !== exp_r.res_high) begin
                        $error("result_high expected %h actual %h", exp_r.res_high,
                               m_tdata[95:64]);
                        errs++;
                    end
                    if (m_tuser !== exp_r.res_zero) begin
                        $error("result_is_zero expected %b actual %b", exp_r.res_zero,
                               m_tuser);
                        errs++;
                    end
                end
            end
            mismatches <= mismatches + errs;
        end
    end
endmodule

// ===== dv/tb_top.sv =====
// top of the extension_field_mul_pow testbench: clock, reset, stimulus, verdict
// depends on the block and on efmp_checker
`timescale 1ns / 100ps

module tb_top;
    localparam logic REQ_MUL = 1'b0;
    localparam logic REQ_POW = 1'b1;
    localparam logic REG_REL_LOW = 1'b0;
    localparam logic REG_REL_HIGH = 1'b1;
    localparam int STALL_LIMIT = 60000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_we = 1'b0;
    logic         cfg_index = 1'b0;
    logic [63:0]  cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [287:0] s_tdata = '0;  // a_low, a_high, b_low, b_high, exp_low, exp_high, zero fill
    logic         s_tuser = 1'b0;  // req_type
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [95:0]  m_tdata;  // result_low, result_high
    logic         m_tuser;  // result_is_zero

    int  mismatches;
    int  awaiting;
    int  quiet_cycles = 0;
    bit  hold_sink = 1'b0;    // asks the sink for one long hold-off
    bit  no_gaps = 1'b0;      // stretches with no idling on either side

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    extension_field_mul_pow dut (.*);

    efmp_checker u_checker (.*);

    // watchdog: cycles with no transfer on either channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // sink side: random ready, mostly short gaps, now and then a long hold-off
    initial begin
        int gap;
        forever begin
            @(posedge aclk);
            if (hold_sink) begin
                m_tready <= 1'b0;
                repeat (3000) @(posedge aclk);
                hold_sink = 1'b0;
            end
            if (no_gaps) begin
                m_tready <= 1'b1;
            end else begin
                gap = $urandom_range(0, 9);
                if (gap < 6) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready <= 1'b0;
                    repeat ((gap == 9) ? $urandom_range(20, 200) : $urandom_range(1, 3))
                        @(posedge aclk);
                end
            end
        end
    end

    // random element: lanes mostly canonical, some at or above the prime
    function automatic logic [95:0] rand_elem();
        logic [95:0] v;
        for (int i = 0; i < 12; i++)
            v[8*i +: 8] = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 166))
                                                      : 8'($urandom_range(0, 255));
        return v;
    endfunction

    function automatic logic [88:0] rand_exponent();
        logic [88:0] e;
        e = 89'({$urandom, $urandom, $urandom});
        case ($urandom_range(0, 3))
            0: e = e & 89'hFF;   // small powers
            1: e = e & 89'hFFFF_FFFF;
            default: ;
        endcase
        return e;
    endfunction

    task automatic write_reg(input logic idx, input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // sender pauses until the block has handed back every expected result
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (awaiting != 0) @(posedge aclk);
    endtask

    task automatic set_relation(input logic [95:0] rel);
        wait_drained();
        write_reg(REG_REL_LOW, rel[63:0]);
        write_reg(REG_REL_HIGH, {32'h0, rel[95:64]});
    endtask

    task automatic send_req(input logic req, input logic [95:0] a, input logic [95:0] b,
                            input logic [88:0] e);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {7'h0, e, b, a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        gap = no_gaps ? 0 : $urandom_range(0, 19);
        if (gap >= 12) begin
            s_tvalid <= 1'b0;
            repeat ((gap == 19) ? $urandom_range(15, 120) : $urandom_range(1, 3))
                @(posedge aclk);
        end
    endtask

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) < 6)
                send_req(REQ_MUL, rand_elem(), rand_elem(),
                         89'({$urandom, $urandom, $urandom}));
            else
                send_req(REQ_POW, ($urandom_range(0, 19) == 0) ? 96'h0 : rand_elem(),
                         {$urandom, $urandom, $urandom}, rand_exponent());
        end
    endtask

    initial begin
        logic [95:0] one_elem;
        logic [95:0] all_ff;
        one_elem = 96'h1;
        all_ff   = {96{1'b1}};
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // relation at its reset value of zero: x^12 folds to nothing
        send_req(REQ_MUL, 96'h0, rand_elem(), 89'h0);
        send_req(REQ_MUL, all_ff, all_ff, 89'h0);
        send_req(REQ_MUL, {8'd1, 88'h0}, {8'd1, 88'h0}, 89'h0);
        send_req(REQ_POW, 96'h0, all_ff, 89'h0);          // zero to the zero gives one
        send_req(REQ_POW, 96'h0, 96'h0, 89'h1);

        // all lanes noncanonical in the relation
        set_relation(all_ff);
        send_req(REQ_MUL, {8'd1, 88'h0}, {8'd2, 88'h0}, {89{1'b1}});
        send_req(REQ_MUL, {12{8'd166}}, {12{8'd166}}, 89'h0);
        send_req(REQ_MUL, {12{8'd167}}, rand_elem(), 89'h0);  // reduces to zero
        send_req(REQ_MUL, one_elem, all_ff, 89'h0);
        send_req(REQ_POW, {8'd1, 88'h0}, all_ff, 89'h0);
        send_req(REQ_POW, {8'd1, 88'h0}, 96'h0, 89'h1);
        send_req(REQ_POW, rand_elem(), 96'h0, {89{1'b1}});
        send_req(REQ_POW, rand_elem(), 96'h0, {1'b1, 88'h0});  // top exponent bit alone
        send_req(REQ_POW, all_ff, 96'h0, {25'h1FF_FFFF, 64'h0});
        send_req(REQ_POW, {12{8'd166}}, rand_elem(), 89'h2);

        // a typical relation, then random traffic with a long sink hold-off
        set_relation(rand_elem() % {12{8'd167}} | 96'h3);
        send_req(REQ_MUL, rand_elem(), rand_elem(), 89'h0);
        send_req(REQ_POW, rand_elem(), rand_elem(), 89'h3);
        hold_sink = 1'b1;
        send_random(30);

        wait_drained();
        no_gaps = 1'b1;
        send_random(30);
        no_gaps = 1'b0;

        set_relation({$urandom, $urandom, $urandom});
        send_random(60);

        set_relation(96'h0);
        send_random(30);

        set_relation(rand_elem());
        send_random(70);

        // end of stimulus: wait for the last results, then a little latency margin
        wait_drained();
        repeat (100) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
